>>> rtl/core/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

   localparam int DefOrderSlots = 32;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_MODIFY = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUP_ID    = 3'd1,
      ST_FAK_NOX   = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_FULL      = 3'd4,
      ST_ZERO_QTY  = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] order_id;
      logic        side;
      logic        order_type;
      logic [31:0] price;
      logic [31:0] quantity;
   } req_type;

   typedef enum logic [3:0] {
      BE_IDLE,
      BE_FIND,
      BE_CHECK,
      BE_FAK,
      BE_INSERT,
      BE_BEST,
      BE_FILL,
      BE_KILL,
      BE_STATUS
   } be_state_type;

endpackage

>>> rtl/core/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book matcher.
//
// Requests (add, cancel, modify) are taken when start is high and busy low
// into a two-word queue; the engine works on one at a time. Each request
// is popped from the queue, sweeps the slot table once for its id, is
// decoded and ends in a status state; a cancel or a rejected add or modify
// stops there, and an unused kind skips the sweep and the decode. An add
// or modify that rests goes on through an insert state, one best-bid and
// best-ask sweep that ends in the crossed-book check, and a kill state. A
// fill-and-kill order sweeps once more for the cross test before it rests.
// Every trade goes through a fill state and then one more best-order sweep.
// Every word on rsp_ is shown for one cycle under rsp_valid, the cycle
// after the fill or status cycle, and cannot be held off; each request
// ends in a status word with rsp_last set.
module limit_order_book_matcher
   import lobm_pkg::*;
#(
   parameter int ORDER_SLOTS = DefOrderSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_order_id,
   input  logic        req_side,
   input  logic        req_order_type,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   output logic        rsp_is_trade,
   output logic [63:0] rsp_bid_id,
   output logic [31:0] rsp_bid_price,
   output logic [63:0] rsp_ask_id,
   output logic [31:0] rsp_ask_price,
   output logic [31:0] rsp_fill_quantity,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_live_orders,
   output logic        rsp_last
);
   req_type in_word, head_word;
   logic    q_full, q_empty, pop;

   assign in_word = '{kind: req_kind, order_id: req_order_id, side: req_side,
                      order_type: req_order_type, price: req_price,
                      quantity: req_quantity};
   // hold off new words while the queue is full
   assign busy = q_full;

   lobm_front u_front (
      .clock, .reset,
      .push      (start && !busy),
      .push_word (in_word),
      .full      (q_full),
      .empty     (q_empty),
      .pop       (pop),
      .head_word (head_word)
   );

   lobm_engine #(.ORDER_SLOTS(ORDER_SLOTS)) u_engine (
      .clock, .reset,
      .have_word (!q_empty),
      .head_word (head_word),
      .pop       (pop),
      .rsp_valid, .rsp_is_trade, .rsp_bid_id, .rsp_bid_price, .rsp_ask_id,
      .rsp_ask_price, .rsp_fill_quantity, .rsp_status, .rsp_live_orders,
      .rsp_last
   );
endmodule

>>> rtl/core/lobm_front.sv
// Front end: accept requests and hold them in a short queue for the engine.
module lobm_front
   import lobm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_word,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output req_type head_word
);
   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop && cnt_ff != 2'd0) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push && cnt_ff != 2'd2) begin
         q_in[cnt_in[0]] = push_word;
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign full      = cnt_ff == 2'd2;
   assign empty     = cnt_ff == 2'd0;
   assign head_word = q_ff[0];
endmodule

>>> rtl/core/lobm_engine.sv
// Back end: slot table, id search, best-order search and matching sequencer.
module lobm_engine
   import lobm_pkg::*;
#(
   parameter int ORDER_SLOTS = DefOrderSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        have_word,
   input  req_type     head_word,
   output logic        pop,
   output logic        rsp_valid,
   output logic        rsp_is_trade,
   output logic [63:0] rsp_bid_id,
   output logic [31:0] rsp_bid_price,
   output logic [63:0] rsp_ask_id,
   output logic [31:0] rsp_ask_price,
   output logic [31:0] rsp_fill_quantity,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_live_orders,
   output logic        rsp_last
);
   localparam int IW = $clog2(ORDER_SLOTS);
   localparam int CW = $clog2(ORDER_SLOTS + 1);

   logic [ORDER_SLOTS-1:0] vld_ff, vld_in;
   logic [63:0] sid_ff  [ORDER_SLOTS];
   logic        sside_ff[ORDER_SLOTS];
   logic        stype_ff[ORDER_SLOTS];
   logic [31:0] sprc_ff [ORDER_SLOTS];
   logic [31:0] srem_ff [ORDER_SLOTS];
   logic [63:0] sarr_ff [ORDER_SLOTS];
   logic [63:0] arr_ff, arr_in;

   be_state_type st_ff, st_in;
   req_type      r_ff, r_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic          scan_last;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          otype_ff, otype_in;
   logic          bv_ff, bv_in, av_ff, av_in;
   logic [IW-1:0] bi_ff, bi_in, ai_ff, ai_in;
   logic [CW-1:0] ntr_ff, ntr_in;
   logic [IW-1:0] ns_ff, ns_in;
   logic [2:0]    stat_ff, stat_in;
   logic [CW-1:0] live;

   // per-slot write controls
   logic          wr_new;
   logic          wr_rem_b, wr_rem_a;
   logic [31:0]   fq;

   logic rv_ff, rv_in, rt_ff, rt_in;
   logic [63:0] rbid_ff, rbid_in, raid_ff, raid_in;
   logic [31:0] rbp_ff, rbp_in, rap_ff, rap_in, rq_ff, rq_in;
   logic [2:0]  rst_ff, rst_in;
   logic [5:0]  rlive_ff, rlive_in;
   logic        rl_ff, rl_in;

   logic [IW-1:0] free_idx;
   logic          free_any;

   always_comb begin
      live = '0;
      for (int i = 0; i < ORDER_SLOTS; i++) live = live + CW'(vld_ff[i]);
      free_any = 1'b0;
      free_idx = '0;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
         if (!vld_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign scan_last = ptr_ff == IW'(ORDER_SLOTS - 1);

   // comparison of the scanned slot against the held best of its side
   logic better;
   logic [IW-1:0] cur_best;
   logic          cur_bv;
   always_comb begin
      cur_best = sside_ff[ptr_ff] ? ai_ff : bi_ff;
      cur_bv   = sside_ff[ptr_ff] ? av_ff : bv_ff;
      if (!cur_bv) begin
         better = 1'b1;
      end else if (sprc_ff[ptr_ff] != sprc_ff[cur_best]) begin
         better = sside_ff[ptr_ff]
            ? ($signed(sprc_ff[ptr_ff]) < $signed(sprc_ff[cur_best]))
            : ($signed(sprc_ff[ptr_ff]) > $signed(sprc_ff[cur_best]));
      end else begin
         better = sarr_ff[ptr_ff] < sarr_ff[cur_best];
      end
   end

   always_comb begin
      st_in = st_ff;  r_in = r_ff;  ptr_in = ptr_ff;
      hit_in = hit_ff;  hit_idx_in = hit_idx_ff;  otype_in = otype_ff;
      bv_in = bv_ff;  av_in = av_ff;  bi_in = bi_ff;  ai_in = ai_ff;
      ntr_in = ntr_ff;  ns_in = ns_ff;  stat_in = stat_ff;
      vld_in = vld_ff;  arr_in = arr_ff;
      wr_new = 1'b0;  wr_rem_b = 1'b0;  wr_rem_a = 1'b0;
      pop = 1'b0;
      rv_in = 1'b0;  rt_in = 1'b0;  rbid_in = '0;  raid_in = '0;
      rbp_in = '0;  rap_in = '0;  rq_in = '0;  rst_in = '0;
      rlive_in = '0;  rl_in = 1'b0;
      fq = (srem_ff[bi_ff] < srem_ff[ai_ff]) ? srem_ff[bi_ff] : srem_ff[ai_ff];
      case (st_ff)
         BE_IDLE: begin
            if (have_word) begin
               pop = 1'b1;  r_in = head_word;
               ptr_in = '0;  hit_in = 1'b0;  ntr_in = '0;
               stat_in = ST_OK;
               st_in = (kind_type'(head_word.kind) == KIND_NONE) ? BE_STATUS : BE_FIND;
            end
         end
         BE_FIND: begin
            // sweep for the id, one slot a cycle
            if (vld_ff[ptr_ff] && sid_ff[ptr_ff] == r_ff.order_id && !hit_ff) begin
               hit_in = 1'b1;  hit_idx_in = ptr_ff;
            end
            ptr_in = ptr_ff + IW'(1);
            if (scan_last) begin
               ptr_in = '0;
               st_in = BE_CHECK;
            end
         end
         BE_CHECK: begin
            bv_in = 1'b0;  av_in = 1'b0;  ptr_in = '0;
            otype_in = r_ff.order_type;
            st_in = BE_STATUS;
            case (kind_type'(r_ff.kind))
               KIND_CANCEL: begin
                  if (!hit_ff) stat_in = ST_UNKNOWN;
                  else vld_in[hit_idx_ff] = 1'b0;
               end
               KIND_MODIFY: begin
                  if (!hit_ff) stat_in = ST_UNKNOWN;
                  else if (r_ff.quantity == '0) stat_in = ST_ZERO_QTY;
                  else begin
                     vld_in[hit_idx_ff] = 1'b0;
                     otype_in = stype_ff[hit_idx_ff];
                     st_in = stype_ff[hit_idx_ff] ? BE_FAK : BE_INSERT;
                  end
               end
               KIND_ADD: begin
                  if (hit_ff) stat_in = ST_DUP_ID;
                  else if (r_ff.quantity == '0) stat_in = ST_ZERO_QTY;
                  else if (!free_any) stat_in = ST_FULL;
                  else st_in = r_ff.order_type ? BE_FAK : BE_INSERT;
               end
               default: stat_in = ST_OK;
            endcase
         end
         BE_FAK: begin
            // find best opposite to test the cross
            if (vld_ff[ptr_ff] && better) begin
               if (sside_ff[ptr_ff]) begin av_in = 1'b1; ai_in = ptr_ff; end
               else begin bv_in = 1'b1; bi_in = ptr_ff; end
            end
            ptr_in = ptr_ff + IW'(1);
            if (scan_last) begin
               ptr_in = '0;
               st_in = BE_INSERT;
               if (r_ff.side == 1'b0) begin
                  if (!av_in || $signed(r_ff.price) < $signed(sprc_ff[ai_in])) begin
                     stat_in = ST_FAK_NOX;  st_in = BE_STATUS;
                  end
               end else begin
                  if (!bv_in || $signed(r_ff.price) > $signed(sprc_ff[bi_in])) begin
                     stat_in = ST_FAK_NOX;  st_in = BE_STATUS;
                  end
               end
            end
         end
         BE_INSERT: begin
            wr_new = 1'b1;
            ns_in = free_idx;
            vld_in[free_idx] = 1'b1;
            arr_in = arr_ff + 64'd1;
            bv_in = 1'b0;  av_in = 1'b0;  ptr_in = '0;
            st_in = BE_BEST;
         end
         BE_BEST: begin
            if (vld_ff[ptr_ff] && better) begin
               if (sside_ff[ptr_ff]) begin av_in = 1'b1; ai_in = ptr_ff; end
               else begin bv_in = 1'b1; bi_in = ptr_ff; end
            end
            ptr_in = ptr_ff + IW'(1);
            if (scan_last) begin
               ptr_in = '0;
               if (bv_in && av_in && !($signed(sprc_ff[bi_in]) < $signed(sprc_ff[ai_in]))
                   && ntr_ff < CW'(ORDER_SLOTS - 1)) st_in = BE_FILL;
               else st_in = BE_KILL;
            end
         end
         BE_FILL: begin
            wr_rem_b = 1'b1;  wr_rem_a = 1'b1;
            if (srem_ff[bi_ff] == fq) vld_in[bi_ff] = 1'b0;
            if (srem_ff[ai_ff] == fq) vld_in[ai_ff] = 1'b0;
            rv_in = 1'b1;  rt_in = 1'b1;
            rbid_in = sid_ff[bi_ff];  rbp_in = sprc_ff[bi_ff];
            raid_in = sid_ff[ai_ff];  rap_in = sprc_ff[ai_ff];  rq_in = fq;
            ntr_in = ntr_ff + CW'(1);
            bv_in = 1'b0;  av_in = 1'b0;
            st_in = BE_BEST;
         end
         BE_KILL: begin
            if (otype_ff && vld_ff[ns_ff] && sid_ff[ns_ff] == r_ff.order_id)
               vld_in[ns_ff] = 1'b0;
            st_in = BE_STATUS;
         end
         BE_STATUS: begin
            rv_in = 1'b1;  rst_in = stat_ff;
            rlive_in = 6'(live);  rl_in = 1'b1;
            st_in = BE_IDLE;
         end
         default: st_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;  ptr_ff <= ptr_in;  hit_ff <= hit_in;  hit_idx_ff <= hit_idx_in;
      otype_ff <= otype_in;  bv_ff <= bv_in;  av_ff <= av_in;
      bi_ff <= bi_in;  ai_ff <= ai_in;  ntr_ff <= ntr_in;  ns_ff <= ns_in;
      stat_ff <= stat_in;
      rt_ff <= rt_in;  rbid_ff <= rbid_in;  raid_ff <= raid_in;
      rbp_ff <= rbp_in;  rap_ff <= rap_in;  rq_ff <= rq_in;
      rst_ff <= rst_in;  rlive_ff <= rlive_in;  rl_ff <= rl_in;
      if (wr_new) begin
         sid_ff[free_idx]   <= r_ff.order_id;
         sside_ff[free_idx] <= r_ff.side;
         stype_ff[free_idx] <= otype_ff;
         sprc_ff[free_idx]  <= r_ff.price;
         srem_ff[free_idx]  <= r_ff.quantity;
         sarr_ff[free_idx]  <= arr_ff;
      end
      if (wr_rem_b) srem_ff[bi_ff] <= srem_ff[bi_ff] - fq;
      if (wr_rem_a) srem_ff[ai_ff] <= srem_ff[ai_ff] - fq;
      if (reset) begin
         st_ff <= BE_IDLE;  vld_ff <= '0;  arr_ff <= '0;  rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  vld_ff <= vld_in;  arr_ff <= arr_in;  rv_ff <= rv_in;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_is_trade      = rt_ff;
   assign rsp_bid_id        = rbid_ff;
   assign rsp_bid_price     = rbp_ff;
   assign rsp_ask_id        = raid_ff;
   assign rsp_ask_price     = rap_ff;
   assign rsp_fill_quantity = rq_ff;
   assign rsp_status        = rst_ff;
   assign rsp_live_orders   = rlive_ff;
   assign rsp_last          = rl_ff;
endmodule
